[rtl/tcw_pkg.sv]
package tcw_pkg;

  // Default geometry and queue depths
  localparam int ROWS_DEF      = 25;
  localparam int COLUMNS_DEF   = 80;
  localparam int CMD_DEPTH_DEF = 4;
  localparam int RES_DEPTH_DEF = 2;

  // Fixed field widths
  localparam int ACT_W  = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 7;
  localparam int ATTR_W = 8;
  localparam int HW_W   = 13;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SETCUR = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_COLOR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  typedef enum logic [3:0] {
    OP_CR,
    OP_LF,
    OP_BS,
    OP_PUT,
    OP_SETCUR,
    OP_CLEAR,
    OP_COLOR,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ATTR_W-1:0] color;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [HW_W-1:0]   hw_cursor_location;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_BLANK,
    ST_CLEAR,
    ST_POST,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

[rtl/tcw_fifo.sv]
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tcw_pkg::RES_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (PTR_W+1)'(1);
      end
    end
  end

endmodule

[rtl/tcw_front.sv]
module tcw_front #(
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int CMD_DEPTH = tcw_pkg::CMD_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        hold,
  input  logic                        push,
  output logic                        full,
  input  logic [tcw_pkg::ACT_W-1:0]   in_action,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  logic [tcw_pkg::COL_W-1:0]   in_column,
  input  logic [tcw_pkg::ATTR_W-1:0]  in_color,
  output logic                        cmd_valid,
  output tcw_pkg::cmd_t               cmd,
  input  logic                        cmd_pop
);

  tcw_pkg::cmd_t cls;
  logic          q_full, q_empty;
  logic [$bits(tcw_pkg::cmd_t)-1:0] q_dout;

  // Classify the incoming item into one engine operation
  always_comb begin
    cls.ch       = in_char_code;
    cls.row      = in_row;
    cls.col      = in_column;
    cls.color    = in_color;
    cls.in_range = ({1'b0, in_row} < (tcw_pkg::ROW_W+1)'(ROWS)) &&
                   ({1'b0, in_column} < (tcw_pkg::COL_W+1)'(COLUMNS));
    case (in_action)
      tcw_pkg::ACT_WRITE: begin
        case (in_char_code)
          tcw_pkg::CH_CR: cls.op = tcw_pkg::OP_CR;
          tcw_pkg::CH_LF: cls.op = tcw_pkg::OP_LF;
          tcw_pkg::CH_BS: cls.op = tcw_pkg::OP_BS;
          default:        cls.op = tcw_pkg::OP_PUT;
        endcase
      end
      tcw_pkg::ACT_SETCUR: cls.op = tcw_pkg::OP_SETCUR;
      tcw_pkg::ACT_CLEAR:  cls.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::ACT_COLOR:  cls.op = tcw_pkg::OP_COLOR;
      tcw_pkg::ACT_READ:   cls.op = tcw_pkg::OP_READ;
      default:             cls.op = tcw_pkg::OP_NONE;
    endcase
  end

  assign full      = q_full || hold;
  assign cmd_valid = !q_empty;
  assign cmd       = tcw_pkg::cmd_t'(q_dout);

  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push && !full),
    .din  (cls),
    .full (q_full),
    .pop  (cmd_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

endmodule

[rtl/tcw_engine.sv]
module tcw_engine #(
  parameter int ROWS    = tcw_pkg::ROWS_DEF,
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          cmd_valid,
  input  tcw_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          res_push,
  output tcw_pkg::res_t res,
  input  logic          res_full,
  output logic          init_busy
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COPY   = COLUMNS * (ROWS - 1);
  localparam int CELL_W = $clog2(CELLS);

  // Split cell store: characters and attributes, so an attribute repaint is a plain write
  logic [tcw_pkg::CHAR_W-1:0] char_mem [CELLS];
  logic [tcw_pkg::ATTR_W-1:0] attr_mem [CELLS];

  tcw_pkg::state_t state_r, state_nxt;
  tcw_pkg::cmd_t   cmd_r;

  logic [CELL_W-1:0]          cnt_r, cnt_nxt;
  logic [tcw_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [tcw_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcw_pkg::ATTR_W-1:0] color_r, color_nxt;
  logic [tcw_pkg::HW_W-1:0]   hw_r, hw_nxt;
  logic [tcw_pkg::CHAR_W-1:0] rdc_r, rdc_nxt;
  logic [tcw_pkg::ATTR_W-1:0] rda_r, rda_nxt;
  logic                       bs_r, bs_nxt;
  logic                       visible_r;

  logic [tcw_pkg::CHAR_W-1:0] char_q_r;
  logic [tcw_pkg::ATTR_W-1:0] attr_q_r;

  logic                       char_we, attr_we;
  logic [CELL_W-1:0]          wr_addr, rd_addr;
  logic [tcw_pkg::CHAR_W-1:0] char_wd;
  logic [tcw_pkg::ATTR_W-1:0] attr_wd;

  logic [CELL_W-1:0] cur_idx, cmd_idx;
  logic              at_last_row, at_last_col;

  assign cur_idx     = CELL_W'(row_r) * CELL_W'(COLUMNS) + CELL_W'(col_r);
  assign cmd_idx     = CELL_W'(cmd_r.row) * CELL_W'(COLUMNS) + CELL_W'(cmd_r.col);
  assign at_last_row = (row_r == tcw_pkg::ROW_W'(ROWS - 1));
  assign at_last_col = (col_r == tcw_pkg::COL_W'(COLUMNS - 1));
  assign init_busy   = (state_r == tcw_pkg::ST_INIT);

  assign res.cursor_row         = row_r;
  assign res.cursor_column      = col_r;
  assign res.hw_cursor_location = hw_r;
  assign res.cell_char          = rdc_r;
  assign res.cell_attribute     = rda_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcw_pkg::ST_INIT: begin
        if (cnt_r == CELL_W'(CELLS - 1)) state_nxt = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (cmd_valid) state_nxt = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        case (cmd_r.op)
          tcw_pkg::OP_CR, tcw_pkg::OP_BS: state_nxt = tcw_pkg::ST_POST;
          tcw_pkg::OP_LF:
            state_nxt = at_last_row ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_POST;
          tcw_pkg::OP_PUT:
            state_nxt = (at_last_col && at_last_row) ? tcw_pkg::ST_SCROLL
                                                     : tcw_pkg::ST_POST;
          tcw_pkg::OP_SETCUR:
            state_nxt = cmd_r.in_range ? tcw_pkg::ST_POST : tcw_pkg::ST_DONE;
          tcw_pkg::OP_CLEAR: state_nxt = tcw_pkg::ST_CLEAR;
          tcw_pkg::OP_READ:
            state_nxt = cmd_r.in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_DONE;
          default: state_nxt = tcw_pkg::ST_DONE;
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        if (cnt_r == CELL_W'(COPY)) state_nxt = tcw_pkg::ST_BLANK;
      end
      tcw_pkg::ST_BLANK: begin
        if (cnt_r == CELL_W'(CELLS - 1)) state_nxt = tcw_pkg::ST_POST;
      end
      tcw_pkg::ST_CLEAR: begin
        if (cnt_r == CELL_W'(CELLS - 1)) state_nxt = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_POST: state_nxt = tcw_pkg::ST_DONE;
      tcw_pkg::ST_READ: state_nxt = tcw_pkg::ST_DONE;
      tcw_pkg::ST_DONE: begin
        if (!res_full) state_nxt = cmd_valid ? tcw_pkg::ST_EXEC : tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_INIT;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    char_we   = 1'b0;
    attr_we   = 1'b0;
    wr_addr   = cur_idx;
    char_wd   = tcw_pkg::CH_BLANK;
    attr_wd   = color_r;
    rd_addr   = cmd_idx;
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    color_nxt = color_r;
    hw_nxt    = hw_r;
    rdc_nxt   = rdc_r;
    rda_nxt   = rda_r;
    bs_nxt    = bs_r;
    case (state_r)
      tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR, tcw_pkg::ST_BLANK: begin
        // blank one cell a cycle
        char_we = 1'b1;
        attr_we = 1'b1;
        wr_addr = cnt_r;
        if (cnt_r != CELL_W'(CELLS - 1)) cnt_nxt = cnt_r + CELL_W'(1);
      end
      tcw_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid;
      end
      tcw_pkg::ST_EXEC: begin
        rdc_nxt = '0;
        rda_nxt = '0;
        bs_nxt  = 1'b0;
        cnt_nxt = '0;
        case (cmd_r.op)
          tcw_pkg::OP_CR: col_nxt = '0;
          tcw_pkg::OP_LF: begin
            col_nxt = '0;
            if (!at_last_row) row_nxt = row_r + tcw_pkg::ROW_W'(1);
          end
          tcw_pkg::OP_BS: begin
            if (row_r != '0 || col_r != '0) begin
              bs_nxt = 1'b1;
              if (col_r != '0) begin
                col_nxt = col_r - tcw_pkg::COL_W'(1);
              end else begin
                col_nxt = tcw_pkg::COL_W'(COLUMNS - 1);
                row_nxt = row_r - tcw_pkg::ROW_W'(1);
              end
            end
          end
          tcw_pkg::OP_PUT: begin
            char_we = 1'b1;
            attr_we = 1'b1;
            char_wd = cmd_r.ch;
            if (at_last_col) begin
              col_nxt = '0;
              if (!at_last_row) row_nxt = row_r + tcw_pkg::ROW_W'(1);
            end else begin
              col_nxt = col_r + tcw_pkg::COL_W'(1);
            end
          end
          tcw_pkg::OP_SETCUR: begin
            if (cmd_r.in_range) begin
              row_nxt = cmd_r.row;
              col_nxt = cmd_r.col;
            end
          end
          tcw_pkg::OP_CLEAR: begin
            row_nxt = '0;
            col_nxt = '0;
          end
          tcw_pkg::OP_COLOR: begin
            color_nxt = cmd_r.color;
            attr_we   = 1'b1;
            attr_wd   = cmd_r.color;
          end
          default: ;
        endcase
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row ahead, write the cell read last cycle
        if (cnt_r != '0) begin
          char_we = 1'b1;
          attr_we = 1'b1;
          wr_addr = cnt_r - CELL_W'(1);
          char_wd = char_q_r;
          attr_wd = attr_q_r;
        end
        if (cnt_r != CELL_W'(COPY)) begin
          rd_addr = cnt_r + CELL_W'(COLUMNS);
          cnt_nxt = cnt_r + CELL_W'(1);
        end
      end
      tcw_pkg::ST_POST: begin
        if (bs_r) begin
          char_we = 1'b1;
          attr_we = 1'b1;
        end
        if (visible_r) begin
          attr_we = 1'b1;
          hw_nxt  = tcw_pkg::HW_W'(cur_idx);
        end
      end
      tcw_pkg::ST_READ: begin
        rdc_nxt = char_q_r;
        rda_nxt = attr_q_r;
      end
      tcw_pkg::ST_DONE: begin
        res_push = !res_full;
        cmd_pop  = !res_full && cmd_valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (char_we) char_mem[wr_addr] <= char_wd;
    if (attr_we) attr_mem[wr_addr] <= attr_wd;
    char_q_r <= char_mem[rd_addr];
    attr_q_r <= attr_mem[rd_addr];
    if (cmd_pop) cmd_r <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tcw_pkg::ST_INIT;
      cnt_r     <= '0;
      row_r     <= '0;
      col_r     <= '0;
      color_r   <= '0;
      hw_r      <= '0;
      rdc_r     <= '0;
      rda_r     <= '0;
      bs_r      <= 1'b0;
      visible_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      color_r <= color_nxt;
      hw_r    <= hw_nxt;
      rdc_r   <= rdc_nxt;
      rda_r   <= rda_nxt;
      bs_r    <= bs_nxt;
      if (cfg_wr_en) visible_r <= cfg_wr_data;
    end
  end

endmodule

[rtl/text_console_writer.sv]
// Text console writer: a ROWS x COLUMNS store of character/attribute cells with a
// cursor, a current color and a hardware cursor location register. Push one item
// (action, char_code, row, column, color) while full is low; every item yields
// exactly one result (cursor row/column after the action, hardware cursor
// location, and the addressed cell for a read, zero otherwise), popped while empty
// is low. After reset the cell store is blanked cell by cell with full held high.
// In steady state the engine takes one item at a time. Set colour, unknown
// actions and out-of-range set cursor or read go from execute straight to done;
// carriage return, line feed, backspace, printable characters, set cursor and
// read cell pass through a further state for the cursor update or the registered
// cell read; clear screen walks every cell; and a write that scrolls first copies
// the lower rows up and blanks the last row, all through the single write port
// of the cell memory. Write cfg_wr_data (cursor visible) with cfg_wr_en only
// while the block is idle.
module text_console_writer #(
  parameter int ROWS      = tcw_pkg::ROWS_DEF,
  parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
  parameter int CMD_DEPTH = tcw_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH = tcw_pkg::RES_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        push,
  output logic                        full,
  input  logic [tcw_pkg::ACT_W-1:0]   in_action,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  logic [tcw_pkg::COL_W-1:0]   in_column,
  input  logic [tcw_pkg::ATTR_W-1:0]  in_color,
  output logic                        empty,
  input  logic                        pop,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_column,
  output logic [tcw_pkg::HW_W-1:0]    out_hw_cursor_location,
  output logic [tcw_pkg::CHAR_W-1:0]  out_cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]  out_cell_attribute
);

  logic          init_busy;
  logic          cmd_valid, cmd_pop;
  tcw_pkg::cmd_t cmd;
  logic          res_push, res_full;
  tcw_pkg::res_t res, res_head;
  logic [$bits(tcw_pkg::res_t)-1:0] res_dout;

  // Front: classify items and queue them so the input side runs ahead of the engine
  tcw_front #(
    .ROWS     (ROWS),
    .COLUMNS  (COLUMNS),
    .CMD_DEPTH(CMD_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .hold        (init_busy),
    .push        (push),
    .full        (full),
    .in_action   (in_action),
    .in_char_code(in_char_code),
    .in_row      (in_row),
    .in_column   (in_column),
    .in_color    (in_color),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  // Back: carry out each operation on the cell memory and cursor state
  tcw_engine #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full),
    .init_busy  (init_busy)
  );

  // Result queue: hold finished items until the consumer pops them
  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .din  (res),
    .full (res_full),
    .pop  (pop),
    .dout (res_dout),
    .empty(empty)
  );

  assign res_head               = tcw_pkg::res_t'(res_dout);
  assign out_cursor_row         = res_head.cursor_row;
  assign out_cursor_column      = res_head.cursor_column;
  assign out_hw_cursor_location = res_head.hw_cursor_location;
  assign out_cell_char          = res_head.cell_char;
  assign out_cell_attribute     = res_head.cell_attribute;

endmodule

[tb/console_checker.sv]
`timescale 1ns / 100ps

module console_checker
  import tcw_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              push,
  input  logic              full,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [COL_W-1:0]  in_column,
  input  logic [ATTR_W-1:0] in_color,
  input  logic              empty,
  input  logic              pop,
  input  logic [ROW_W-1:0]  out_cursor_row,
  input  logic [COL_W-1:0]  out_cursor_column,
  input  logic [HW_W-1:0]   out_hw_cursor_location,
  input  logic [CHAR_W-1:0] out_cell_char,
  input  logic [ATTR_W-1:0] out_cell_attribute,
  output int                fail_count,
  output int                outstanding
);

  localparam int CELLS = ROWS * COLUMNS;

  // Shadow copy of the screen and the console registers
  logic [CHAR_W-1:0] char_mem [CELLS];
  logic [ATTR_W-1:0] attr_mem [CELLS];
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ATTR_W-1:0] pen_color;
  logic [HW_W-1:0]   hw_loc;
  logic              visible;

  res_t status_q[$];
  int   errors = 0;

  function automatic int cursor_cell();
    int idx;
    idx = int'(cur_row) * COLUMNS + int'(cur_col);
    return (idx < CELLS) ? idx : 0;
  endfunction

  task automatic scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) begin
      char_mem[i] = char_mem[i + COLUMNS];
      attr_mem[i] = attr_mem[i + COLUMNS];
    end
    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
      char_mem[i] = CH_BLANK;
      attr_mem[i] = pen_color;
    end
  endtask

  task automatic next_line();
    cur_col = '0;
    if (int'(cur_row) >= ROWS - 1) begin
      scroll_screen();
      cur_row = ROW_W'(ROWS - 1);
    end else begin
      cur_row = cur_row + ROW_W'(1);
    end
  endtask

  task automatic move_hw_cursor();
    hw_loc = HW_W'(cursor_cell());
    attr_mem[cursor_cell()] = pen_color;
  endtask

  task automatic write_glyph(input logic [CHAR_W-1:0] ch);
    int next_col;
    if (ch == CH_CR) begin
      cur_col = '0;
    end else if (ch == CH_LF) begin
      next_line();
    end else if (ch == CH_BS) begin
      // backspace at top-left is a no-op
      if (cur_col != '0 || cur_row != '0) begin
        if (cur_col != '0) begin
          cur_col = cur_col - COL_W'(1);
        end else begin
          cur_col = COL_W'(COLUMNS - 1);
          cur_row = cur_row - ROW_W'(1);
        end
        char_mem[cursor_cell()] = CH_BLANK;
        attr_mem[cursor_cell()] = pen_color;
      end
    end else begin
      char_mem[cursor_cell()] = ch;
      attr_mem[cursor_cell()] = pen_color;
      next_col = int'(cur_col) + 1;
      if (next_col >= COLUMNS) next_line();
      else cur_col = COL_W'(next_col);
    end
    if (visible) move_hw_cursor();
  endtask

  task automatic apply_console_action(
    input  logic [ACT_W-1:0]  act,
    input  logic [CHAR_W-1:0] ch,
    input  logic [ROW_W-1:0]  r,
    input  logic [COL_W-1:0]  c,
    input  logic [ATTR_W-1:0] colr,
    output res_t              status
  );
    bit in_screen;
    int idx;
    in_screen = int'(r) < ROWS && int'(c) < COLUMNS;
    idx = int'(r) * COLUMNS + int'(c);
    status = '0;
    case (act)
      ACT_WRITE: write_glyph(ch);
      ACT_SETCUR: begin
        if (in_screen) begin
          cur_row = r;
          cur_col = c;
          if (visible) move_hw_cursor();
        end
      end
      ACT_CLEAR: begin
        cur_row = '0;
        cur_col = '0;
        for (int i = 0; i < CELLS; i++) begin
          char_mem[i] = CH_BLANK;
          attr_mem[i] = pen_color;
        end
      end
      ACT_COLOR: begin
        // repaint under the cursor whatever the cursor visibility
        pen_color = colr;
        attr_mem[cursor_cell()] = pen_color;
      end
      ACT_READ: begin
        if (in_screen) begin
          status.cell_char      = char_mem[idx];
          status.cell_attribute = attr_mem[idx];
        end
      end
      default: ;
    endcase
    status.cursor_row         = cur_row;
    status.cursor_column      = cur_col;
    status.hw_cursor_location = hw_loc;
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("ERROR %s: expected %0d, got %0d at %0t", field, want, got, $time);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t pred;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        char_mem[i] = CH_BLANK;
        attr_mem[i] = '0;
      end
      cur_row   = '0;
      cur_col   = '0;
      pen_color = '0;
      hw_loc    = '0;
      visible   = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_wr_en) visible = cfg_wr_data;
      // retire the oldest expectation before adding one from this edge
      if (pop && !empty) begin
        if (status_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR result with no item pending at %0t", $time);
        end else begin
          want = status_q.pop_front();
          compare_field("cursor_row", int'(want.cursor_row), int'(out_cursor_row));
          compare_field("cursor_column", int'(want.cursor_column),
                        int'(out_cursor_column));
          compare_field("hw_cursor_location", int'(want.hw_cursor_location),
                        int'(out_hw_cursor_location));
          compare_field("cell_char", int'(want.cell_char), int'(out_cell_char));
          compare_field("cell_attribute", int'(want.cell_attribute),
                        int'(out_cell_attribute));
        end
      end
      if (push && !full) begin
        apply_console_action(in_action, in_char_code, in_row, in_column, in_color, pred);
        status_q.push_back(pred);
      end
    end
    fail_count  <= errors;
    outstanding <= status_q.size();
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import tcw_pkg::*;

  localparam int ROWS    = ROWS_DEF;
  localparam int COLUMNS = COLUMNS_DEF;

  // Codes the block does not know; it must leave its state alone for them
  localparam logic [ACT_W-1:0] ACT_UNKNOWN_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN_HI = 3'd7;

  // Idle cycles allowed with no item moving on either side. The slowest
  // honest stretch is a long receiver hold-off stacked on a few full-screen
  // walks (clear or scroll) queued inside the block; take that several times over.
  localparam int STALL_LIMIT = 40000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              push;
  logic              full;
  logic [ACT_W-1:0]  in_action;
  logic [CHAR_W-1:0] in_char_code;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_column;
  logic [ATTR_W-1:0] in_color;
  logic              empty;
  logic              pop;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_column;
  logic [HW_W-1:0]   out_hw_cursor_location;
  logic [CHAR_W-1:0] out_cell_char;
  logic [ATTR_W-1:0] out_cell_attribute;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;

  text_console_writer #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .push                   (push),
    .full                   (full),
    .in_action              (in_action),
    .in_char_code           (in_char_code),
    .in_row                 (in_row),
    .in_column              (in_column),
    .in_color               (in_color),
    .empty                  (empty),
    .pop                    (pop),
    .out_cursor_row         (out_cursor_row),
    .out_cursor_column      (out_cursor_column),
    .out_hw_cursor_location (out_hw_cursor_location),
    .out_cell_char          (out_cell_char),
    .out_cell_attribute     (out_cell_attribute)
  );

  console_checker #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) checker_inst (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .push                   (push),
    .full                   (full),
    .in_action              (in_action),
    .in_char_code           (in_char_code),
    .in_row                 (in_row),
    .in_column              (in_column),
    .in_color               (in_color),
    .empty                  (empty),
    .pop                    (pop),
    .out_cursor_row         (out_cursor_row),
    .out_cursor_column      (out_cursor_column),
    .out_hw_cursor_location (out_hw_cursor_location),
    .out_cell_char          (out_cell_char),
    .out_cell_attribute     (out_cell_attribute),
    .fail_count             (fail_count),
    .outstanding            (outstanding)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog: count cycles in which no item moves on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT - 1) begin
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Rows and columns cluster at the screen corners so that reads land on
  // cells that writes and scrolls have touched; the rest spans the whole
  // field, out-of-range values included.
  function automatic logic [ROW_W-1:0] hot_row();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return ROW_W'($urandom_range(0, 63));
    if (r < 5) return ROW_W'($urandom_range(0, 2));
    return ROW_W'($urandom_range(ROWS - 3, ROWS - 1));
  endfunction

  function automatic logic [COL_W-1:0] hot_column();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return COL_W'($urandom_range(0, 127));
    if (r < 6) return COL_W'($urandom_range(0, 11));
    return COL_W'($urandom_range(COLUMNS - 6, COLUMNS - 1));
  endfunction

  // Control characters show up far more often than in plain text
  function automatic logic [CHAR_W-1:0] glyph_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return CH_LF;
    if (r < 20) return CH_CR;
    if (r < 30) return CH_BS;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Offer one item and hold it until the block takes it. Push stays high on
  // return so that back-to-back items need no second assignment in a step.
  task automatic send_item(
    input logic [ACT_W-1:0]  act,
    input logic [CHAR_W-1:0] ch,
    input logic [ROW_W-1:0]  r,
    input logic [COL_W-1:0]  c,
    input logic [ATTR_W-1:0] colr
  );
    int gap;
    if ($urandom_range(0, 47) == 0) sender_steady = !sender_steady;
    gap = sender_steady ? 0 : idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action    <= act;
    in_char_code <= ch;
    in_row       <= r;
    in_column    <= c;
    in_color     <= colr;
    push         <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic [ACT_W-1:0]  act;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  r;
    logic [COL_W-1:0]  c;
    logic [ATTR_W-1:0] colr;
    int pick;
    // unused fields still get random bits
    ch   = CHAR_W'($urandom_range(0, 255));
    r    = ROW_W'($urandom_range(0, 63));
    c    = COL_W'($urandom_range(0, 127));
    colr = ATTR_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      act = ACT_WRITE;
      ch  = glyph_pick();
    end else if (pick < 70) begin
      act = ACT_SETCUR;
      r   = hot_row();
      c   = hot_column();
    end else if (pick < 72) begin
      // clears walk the whole screen: keep them rare
      act = ACT_CLEAR;
    end else if (pick < 82) begin
      act = ACT_COLOR;
    end else if (pick < 97) begin
      act = ACT_READ;
      r   = hot_row();
      c   = hot_column();
    end else begin
      act = ACT_W'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
    end
    send_item(act, ch, r, c, colr);
  endtask

  // Drop push and wait until every item has come back out
  task automatic drain_engine();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cursor_visible(input bit on);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Stimulus
  initial begin
    rst_n        <= 1'b0;
    push         <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 1'b0;
    in_action    <= ACT_WRITE;
    in_char_code <= '0;
    in_row       <= '0;
    in_column    <= '0;
    in_color     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, hardware cursor hidden
    set_cursor_visible(1'b0);
    send_item(ACT_READ,   '0,     '0, '0, '0);        // blank cell after reset
    send_item(ACT_WRITE,  8'h41,  '0, '0, '0);
    send_item(ACT_WRITE,  8'h00,  '0, '0, '0);        // code zero is printable
    send_item(ACT_WRITE,  8'hFF,  '0, '0, '0);
    send_item(ACT_WRITE,  CH_BS,  '0, '0, '0);
    send_item(ACT_WRITE,  CH_CR,  '0, '0, '0);
    send_item(ACT_WRITE,  CH_BS,  '0, '0, '0);        // backspace at top-left
    send_item(ACT_COLOR,  '0,     '0, '0, 8'hFF);
    send_item(ACT_WRITE,  8'h7E,  '0, '0, '0);
    send_item(ACT_SETCUR, '0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1), '0);
    send_item(ACT_WRITE,  8'h5A,  '0, '0, '0);        // wrap off the last cell: scroll
    send_item(ACT_SETCUR, '0,     6'd63, 7'd127, '0); // out of range, ignored
    send_item(ACT_WRITE,  CH_LF,  '0, '0, '0);        // line feed on the last row
    send_item(ACT_READ,   '0, ROW_W'(ROWS - 2), '0, '0);
    send_item(ACT_READ,   '0,     6'd63, 7'd127, '0);
    send_item(ACT_UNKNOWN_LO, 8'hFF, 6'd63, 7'd127, 8'hFF);
    send_item(ACT_UNKNOWN_HI, '0, '0, '0, '0);
    drain_engine();

    // Directed, hardware cursor shown
    set_cursor_visible(1'b1);
    send_item(ACT_SETCUR, '0,     6'd1, '0, '0);
    send_item(ACT_WRITE,  CH_BS,  '0, '0, '0);        // back onto the previous row
    send_item(ACT_COLOR,  '0,     '0, '0, 8'h3C);
    send_item(ACT_WRITE,  CH_LF,  '0, '0, '0);
    send_item(ACT_SETCUR, '0, ROW_W'(ROWS), '0, '0);  // row just past the screen
    send_item(ACT_CLEAR,  '0,     '0, '0, '0);
    send_item(ACT_READ,   '0,     '0, COL_W'(COLUMNS - 1), '0);
    send_item(ACT_READ,   '0, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1), '0);
    drain_engine();

    // Random phases, alternating cursor visibility
    for (int phase = 0; phase < 4; phase++) begin
      set_cursor_visible(phase % 2 == 0);
      repeat (410) send_random_item();
      drain_engine();
    end

    // Let any stray result surface before the verdict
    repeat (100) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result side: random stalls, plus a long hold-off every few hundred
  // results so that the block backs up and raises full toward the sender
  initial begin
    int stall;
    int pops_since_hold;
    int next_hold;
    pop <= 1'b0;
    pops_since_hold = 0;
    next_hold = 150;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 47) == 0) receiver_steady = !receiver_steady;
      stall = receiver_steady ? 0 : idle_gap();
      if (pops_since_hold >= next_hold) begin
        stall = $urandom_range(400, 800);
        pops_since_hold = 0;
        next_hold = $urandom_range(300, 600);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      pops_since_hold++;
    end
  end

endmodule
